[rtl/core/hesf_pkg.sv]
// Shared types and constants for the hit event selection filter.
package hesf_pkg;

  // Field widths
  localparam int ID_W     = 16;
  localparam int INDEX_W  = 8;
  localparam int ENERGY_W = 24;
  localparam int Z_W      = 16;
  localparam int LAYER_W  = 4;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;

  // Layer thresholds in raw Q11.4 units: 11.5 cm top, 1.5 cm per layer
  localparam int Z_TOP_RAW  = 184;
  localparam int Z_STEP_RAW = 24;

  // Hit index that passes the index check
  localparam logic [INDEX_W-1:0] INDEX_ONE = INDEX_W'(1);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SELECT_MODE       = 3'd0,
    REG_ENERGY_LOW        = 3'd1,
    REG_ENERGY_HIGH       = 3'd2,
    REG_TARGET_LAYER      = 3'd3,
    REG_REQUIRE_INDEX_ONE = 3'd4,
    REG_UNIQUE_ONLY       = 3'd5
  } cfg_reg_t;

  // Selection criterion
  typedef enum logic {
    MODE_ENERGY = 1'b0,
    MODE_LAYER  = 1'b1
  } sel_mode_t;

  // Configuration register set
  typedef struct packed {
    sel_mode_t           select_mode;
    logic [ENERGY_W-1:0] energy_low;
    logic [ENERGY_W-1:0] energy_high;
    logic [LAYER_W-1:0]  target_layer;
    logic                require_index_one;
    logic                unique_only;
  } cfg_t;

endpackage

[rtl/core/hesf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module hesf_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read returns the contents before a write at the same edge
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/hesf_hit_check.sv]
// Per-hit qualification: index check, energy window or layer match.
module hesf_hit_check #(
  parameter int NUM_LAYERS = 10
) (
  input  hesf_pkg::cfg_t                      cfg,
  input  logic [hesf_pkg::INDEX_W-1:0]        hit_index,
  input  logic [hesf_pkg::ENERGY_W-1:0]       hit_energy,
  input  logic signed [hesf_pkg::Z_W-1:0]     hit_z,
  output logic                                qualifies
);

  logic [NUM_LAYERS:1]           above;
  logic [hesf_pkg::LAYER_W-1:0]  layer;
  logic                          index_ok;
  logic                          in_window;
  logic                          layer_ok;

  // z strictly above each layer threshold, all compares in parallel
  for (genvar k = 1; k <= NUM_LAYERS; k++) begin : g_thr
    localparam logic signed [hesf_pkg::Z_W-1:0] THR =
      hesf_pkg::Z_W'(hesf_pkg::Z_TOP_RAW - hesf_pkg::Z_STEP_RAW * (k - 1));
    assign above[k] = hit_z > THR;
  end

  // First layer whose threshold is passed, 0 when none
  always_comb begin
    layer = '0;
    for (int k = NUM_LAYERS; k >= 1; k--) begin
      if (above[k]) begin
        layer = hesf_pkg::LAYER_W'(k);
      end
    end
  end

  // Closed window, either bound order
  assign in_window = ((hit_energy >= cfg.energy_low) && (hit_energy <= cfg.energy_high)) ||
                     ((hit_energy >= cfg.energy_high) && (hit_energy <= cfg.energy_low));

  assign layer_ok = (layer == cfg.target_layer);
  assign index_ok = !cfg.require_index_one || (hit_index == hesf_pkg::INDEX_ONE);

  assign qualifies = index_ok &&
                     ((cfg.select_mode == hesf_pkg::MODE_ENERGY) ? in_window : layer_ok);

endmodule

[rtl/core/hit_event_selection_filter.sv]
// Top level of the hit event selection filter.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready  | event_id, hit_index, hit_energy, hit_z, last_hit
//   out_    | output    | out_valid / out_ready| selected_id
//   cfg_    | input     | cfg_we (no wait)     | cfg_index, cfg_wdata
//
// One hit per cycle while the output is not stalled; out_valid rises when the last hit
// of a selected event passes from the hit stage register into the output register.
// After reset the ID bitmap is cleared one entry per cycle, all 2**ID_BITS entries,
// with in_ready low. Configuration writes are taken at any time.
// When out_valid is high and out_ready is low the hit stage holds, and in_ready drops once it is full.
module hit_event_selection_filter #(
  parameter int ID_BITS    = 16,
  parameter int NUM_LAYERS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // hit input
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [hesf_pkg::ID_W-1:0]              in_event_id,
  input  logic [hesf_pkg::INDEX_W-1:0]           in_hit_index,
  input  logic [hesf_pkg::ENERGY_W-1:0]          in_hit_energy,
  input  logic signed [hesf_pkg::Z_W-1:0]        in_hit_z,
  input  logic                                   in_last_hit,
  // selected event output
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [hesf_pkg::ID_W-1:0]              out_selected_id,
  // configuration
  input  logic                                   cfg_we,
  input  logic [hesf_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hesf_pkg::CFG_W-1:0]             cfg_wdata
);

  localparam int DEPTH = 2 ** ID_BITS;

  hesf_pkg::cfg_t cfg_r;

  // Hit stage
  logic                               s1_v_r;
  logic [hesf_pkg::ID_W-1:0]          s1_event_id_r;
  logic [hesf_pkg::INDEX_W-1:0]       s1_hit_index_r;
  logic [hesf_pkg::ENERGY_W-1:0]      s1_hit_energy_r;
  logic signed [hesf_pkg::Z_W-1:0]    s1_hit_z_r;
  logic                               s1_last_r;
  logic [ID_BITS-1:0]                 s1_slot;
  logic                               s1_adv;
  logic                               qual;

  // Event state and output
  logic                               matched_r;
  logic                               matched_nxt;
  logic                               any_match;
  logic                               seen;
  logic                               emit;
  logic                               bm_set;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [hesf_pkg::ID_W-1:0]          out_id_r;

  // Bitmap forwarding of the write done at the last stage advance
  logic                               fwd_v_r;
  logic [ID_BITS-1:0]                 fwd_slot_r;

  // Clearing pass
  logic                               clearing_r;
  logic [ID_BITS-1:0]                 clr_addr_r;

  // Bitmap port
  logic                               ram_we;
  logic [ID_BITS-1:0]                 ram_waddr;
  logic [0:0]                         ram_wdata;
  logic                               ram_re;
  logic [ID_BITS-1:0]                 ram_raddr;
  logic [0:0]                         ram_rdata;

  logic                               in_xfer;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.select_mode       <= hesf_pkg::MODE_ENERGY;
      cfg_r.energy_low        <= '0;
      cfg_r.energy_high       <= '1;
      cfg_r.target_layer      <= hesf_pkg::LAYER_W'(1);
      cfg_r.require_index_one <= 1'b0;
      cfg_r.unique_only       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        hesf_pkg::REG_SELECT_MODE:
          cfg_r.select_mode <= hesf_pkg::sel_mode_t'(cfg_wdata[0]);
        hesf_pkg::REG_ENERGY_LOW:        cfg_r.energy_low        <= cfg_wdata;
        hesf_pkg::REG_ENERGY_HIGH:       cfg_r.energy_high       <= cfg_wdata;
        hesf_pkg::REG_TARGET_LAYER:
          cfg_r.target_layer <= cfg_wdata[hesf_pkg::LAYER_W-1:0];
        hesf_pkg::REG_REQUIRE_INDEX_ONE: cfg_r.require_index_one <= cfg_wdata[0];
        hesf_pkg::REG_UNIQUE_ONLY:       cfg_r.unique_only       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign s1_adv   = s1_v_r && (!out_valid_r || out_ready);
  assign in_ready = !clearing_r && (!s1_v_r || s1_adv);
  assign in_xfer  = in_valid && in_ready;

  // Hit stage registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_xfer) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_event_id_r   <= in_event_id;
      s1_hit_index_r  <= in_hit_index;
      s1_hit_energy_r <= in_hit_energy;
      s1_hit_z_r      <= in_hit_z;
      s1_last_r       <= in_last_hit;
    end
  end

  assign s1_slot = ID_BITS'(s1_event_id_r);

  hesf_hit_check #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_hit_check (
    .cfg        (cfg_r),
    .hit_index  (s1_hit_index_r),
    .hit_energy (s1_hit_energy_r),
    .hit_z      (s1_hit_z_r),
    .qualifies  (qual)
  );

  // Event decision
  assign any_match   = matched_r || qual;
  assign seen        = ram_rdata[0] || (fwd_v_r && (fwd_slot_r == s1_slot));
  assign bm_set      = s1_last_r && any_match && cfg_r.unique_only && !seen && s1_adv;
  assign emit        = s1_last_r && any_match && !(cfg_r.unique_only && seen);
  assign matched_nxt = s1_adv ? (any_match && !s1_last_r) : matched_r;

  always_comb begin
    if (s1_adv) begin
      out_valid_nxt = emit;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matched_r   <= 1'b0;
      out_valid_r <= 1'b0;
      fwd_v_r     <= 1'b0;
    end else begin
      matched_r   <= matched_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        fwd_v_r <= bm_set;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_id_r   <= s1_event_id_r;
      fwd_slot_r <= s1_slot;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_selected_id = out_id_r;

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clearing_r) begin
      clr_addr_r <= clr_addr_r + ID_BITS'(1);
      if (clr_addr_r == '1) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Emitted-ID bitmap
  assign ram_we    = clearing_r || bm_set;
  assign ram_waddr = clearing_r ? clr_addr_r : s1_slot;
  assign ram_wdata = clearing_r ? 1'b0 : 1'b1;
  assign ram_re    = in_xfer;
  assign ram_raddr = ID_BITS'(in_event_id);

  hesf_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Checks
  a_no_input_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !in_ready && !s1_v_r)
    else $error("input taken during bitmap clear");

  a_no_output_without_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !emit) |=> !out_valid_r)
    else $error("result without selected event");

  a_match_cleared_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> !matched_r)
    else $error("event match kept past last hit");

  a_bitmap_set_only_unique: assert property (@(posedge clk) disable iff (!rst_n)
    bm_set |-> cfg_r.unique_only && emit && !clearing_r)
    else $error("bitmap written outside unique mode");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("hit stage overwritten while stalled");

endmodule
